### rtl/svbm_pkg.sv
// ----------------------------------------------------------------------------
// svbm_pkg
// Shared types and constants of the servo bus transaction master.
// ----------------------------------------------------------------------------
package svbm_pkg;

  // input action codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_RX    = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SERVO_ID       = 2'd0;
  localparam logic [1:0] CFG_HEADER_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_BODY_TIMEOUT   = 2'd2;

  // completion status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_TIMEOUT      = 3'd1;
  localparam logic [2:0] ST_HEADER       = 3'd2;
  localparam logic [2:0] ST_WRONG_ID     = 3'd3;
  localparam logic [2:0] ST_SIZE         = 3'd4;
  localparam logic [2:0] ST_BODY_TIMEOUT = 3'd5;
  localparam logic [2:0] ST_CHECKSUM     = 3'd6;

  // result kinds
  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // frame constants
  localparam logic [7:0] HDR_BYTE   = 8'hFF;
  localparam logic [7:0] MIN_LENGTH = 8'd2;

  // queue depths
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_RX,
    CMD_TICK
  } cmd_kind_t;

  // classified request from front to back
  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       instruction;
    logic [2:0]       count;
    logic [3:0][7:0]  params;
    logic [7:0]       rx_byte;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [2:0]  status;
    logic [7:0]  servo_error;
    logic [31:0] read_value;
    logic [7:0]  param_count;
  } result_t;

  // settings handed to the back end
  typedef struct packed {
    logic [7:0]  servo_id;
    logic [15:0] header_timeout;
    logic [15:0] body_timeout;
  } cfg_t;

endpackage

### rtl/svbm_front.sv
// ----------------------------------------------------------------------------
// svbm_front
// Accepts input requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module svbm_front
  import svbm_pkg::*;
#(
  parameter int MAX_TX_PARAMS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] action,
  input  logic [7:0] instruction,
  input  logic [2:0] param_count,
  input  logic [7:0] param0,
  input  logic [7:0] param1,
  input  logic [7:0] param2,
  input  logic [7:0] param3,
  input  logic [7:0] rx_byte,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);

  localparam int TxLimit = (MAX_TX_PARAMS < 4) ? MAX_TX_PARAMS : 4;
  localparam int PtrW    = $clog2(CMD_DEPTH);
  localparam int CntW    = $clog2(CMD_DEPTH + 1);

  cmd_t            q [CMD_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  cmd_t            cls;
  logic            cls_keep;
  logic            wr_en;

  // classify the incoming request, unknown actions are dropped
  always_comb begin
    cls             = '0;
    cls_keep        = 1'b1;
    cls.instruction = instruction;
    cls.params      = {param3, param2, param1, param0};
    cls.rx_byte     = rx_byte;
    cls.count       = (param_count > 3'(TxLimit)) ? 3'(TxLimit) : param_count;
    case (action)
      ACT_START: cls.kind = CMD_START;
      ACT_RX:    cls.kind = CMD_RX;
      ACT_TICK:  cls.kind = CMD_TICK;
      default: begin
        cls.kind = CMD_TICK;
        cls_keep = 1'b0;
      end
    endcase
  end

  assign full      = (fill == CntW'(CMD_DEPTH));
  assign cmd_valid = (fill != '0);
  assign cmd       = q[rd_ptr];
  assign wr_en     = push && !full && cls_keep;

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CntW'(wr_en) - CntW'(cmd_pop);
    end
  end

endmodule

### rtl/svbm_back.sv
// ----------------------------------------------------------------------------
// svbm_back
// Carries out queued requests: sends command frames and parses the reply.
// ----------------------------------------------------------------------------
module svbm_back
  import svbm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  output logic    res_push,
  output result_t res,
  input  logic    res_full
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR1,
    PH_HDR2,
    PH_ID,
    PH_LEN,
    PH_BODY
  } phase_t;

  phase_t          phase;
  logic [7:0]      reply_index;
  logic [7:0]      reply_length;
  logic [7:0]      running_sum;
  logic [7:0]      error_byte;
  logic [31:0]     value_acc;
  logic [15:0]     tick_count;

  // frame being sent
  logic            tx_active;
  logic [3:0]      tx_pos;
  logic [2:0]      f_count;
  logic [7:0]      f_id;
  logic [7:0]      f_instr;
  logic [3:0][7:0] f_params;
  logic [7:0]      f_chk;

  logic [7:0]      start_sum;
  logic [7:0]      tx_sel;
  logic            tx_last;
  logic [1:0]      pidx;
  logic            fin;
  logic [2:0]      fin_status;
  logic [15:0]     tick_next;
  logic            in_body;
  logic [15:0]     limit;
  logic [7:0]      b;

  assign b = cmd.rx_byte;

  // checksum of the frame to start
  always_comb begin
    start_sum = cfg.servo_id + {5'd0, cmd.count} + 8'd2 + cmd.instruction;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < cmd.count) begin
        start_sum = start_sum + cmd.params[k];
      end
    end
  end

  // transmit byte selection
  always_comb begin
    pidx    = 2'(tx_pos - 4'd5);
    tx_last = (tx_pos == ({1'b0, f_count} + 4'd5));
    case (tx_pos)
      4'd0, 4'd1: tx_sel = HDR_BYTE;
      4'd2:       tx_sel = f_id;
      4'd3:       tx_sel = {5'd0, f_count} + 8'd2;
      4'd4:       tx_sel = f_instr;
      default:    tx_sel = tx_last ? f_chk : f_params[pidx];
    endcase
  end

  // tick counter and active limit
  always_comb begin
    tick_next = (tick_count == 16'hFFFF) ? tick_count : tick_count + 16'd1;
    in_body   = (phase == PH_BODY) && (reply_index != 8'd0);
    limit     = in_body ? cfg.body_timeout : cfg.header_timeout;
  end

  // decide whether this request ends the transaction
  always_comb begin
    fin        = 1'b0;
    fin_status = ST_OK;
    case (cmd.kind)
      CMD_RX: begin
        case (phase)
          PH_HDR1, PH_HDR2: begin
            fin        = (b != HDR_BYTE);
            fin_status = ST_HEADER;
          end
          PH_ID: begin
            fin        = (b != cfg.servo_id);
            fin_status = ST_WRONG_ID;
          end
          PH_LEN: begin
            fin        = (b < MIN_LENGTH);
            fin_status = ST_SIZE;
          end
          PH_BODY: begin
            fin        = (reply_index != 8'd0) && (reply_index == reply_length - 8'd1);
            fin_status = (~running_sum == b) ? ST_OK : ST_CHECKSUM;
          end
          default: fin = 1'b0;
        endcase
      end
      CMD_TICK: begin
        fin        = (phase != PH_IDLE) && (tick_next >= limit);
        fin_status = in_body ? ST_BODY_TIMEOUT : ST_TIMEOUT;
      end
      default: fin = 1'b0;
    endcase
  end

  // result build and handshakes
  always_comb begin
    cmd_pop  = cmd_valid && !tx_active && !res_full;
    res      = '0;
    res_push = 1'b0;
    if (tx_active) begin
      res_push    = !res_full;
      res.kind    = KIND_TX;
      res.tx_byte = tx_sel;
      res.tx_last = tx_last;
    end else begin
      res_push   = cmd_pop && fin;
      res.kind   = KIND_DONE;
      res.status = fin_status;
      if (fin_status == ST_OK) begin
        res.servo_error = error_byte;
        res.read_value  = value_acc;
        res.param_count = reply_length - MIN_LENGTH;
      end
    end
  end

  // state and frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tx_active    <= 1'b0;
      tx_pos       <= '0;
      reply_index  <= '0;
      reply_length <= '0;
      running_sum  <= '0;
      error_byte   <= '0;
      value_acc    <= '0;
      tick_count   <= '0;
    end else begin
      // frame emission, one byte a cycle while the result queue is not full
      if (tx_active && !res_full) begin
        tx_pos <= tx_pos + 4'd1;
        if (tx_last) begin
          tx_active <= 1'b0;
        end
      end
      if (cmd_pop) begin
        if (fin) begin
          phase        <= PH_IDLE;
          reply_index  <= '0;
          reply_length <= '0;
          running_sum  <= '0;
          error_byte   <= '0;
          value_acc    <= '0;
          tick_count   <= '0;
        end else begin
          case (cmd.kind)
            CMD_START: begin
              if (phase == PH_IDLE) begin
                phase        <= PH_HDR1;
                tx_active    <= 1'b1;
                tx_pos       <= '0;
                f_count      <= cmd.count;
                f_id         <= cfg.servo_id;
                f_instr      <= cmd.instruction;
                f_params     <= cmd.params;
                f_chk        <= ~start_sum;
                reply_index  <= '0;
                reply_length <= '0;
                running_sum  <= '0;
                error_byte   <= '0;
                value_acc    <= '0;
                tick_count   <= '0;
              end
            end
            CMD_RX: begin
              case (phase)
                PH_HDR1: phase <= PH_HDR2;
                PH_HDR2: phase <= PH_ID;
                PH_ID: begin
                  running_sum <= b;
                  phase       <= PH_LEN;
                end
                PH_LEN: begin
                  reply_length <= b;
                  running_sum  <= running_sum + b;
                  reply_index  <= '0;
                  phase        <= PH_BODY;
                end
                PH_BODY: begin
                  running_sum <= running_sum + b;
                  reply_index <= reply_index + 8'd1;
                  if (reply_index == 8'd0) begin
                    error_byte <= b;
                    tick_count <= '0;
                  end
                  // first four reply parameters, little-endian
                  for (int k = 0; k < 4; k++) begin
                    if (reply_index == 8'(k + 1)) begin
                      value_acc[k*8 +: 8] <= value_acc[k*8 +: 8] | b;
                    end
                  end
                end
                default: phase <= phase;
              endcase
            end
            CMD_TICK: begin
              if (phase != PH_IDLE) begin
                tick_count <= tick_next;
              end
            end
            default: phase <= phase;
          endcase
        end
      end
    end
  end

endmodule

### rtl/svbm_out_fifo.sv
// ----------------------------------------------------------------------------
// svbm_out_fifo
// Result queue that parts the back end from the result consumer.
// ----------------------------------------------------------------------------
module svbm_out_fifo
  import svbm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t wr_item,
  output logic    full,
  input  logic    pop,
  output logic    empty,
  output result_t rd_item
);

  localparam int PtrW = $clog2(OUT_DEPTH);
  localparam int CntW = $clog2(OUT_DEPTH + 1);

  result_t         mem [OUT_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            wr_en;
  logic            rd_en;

  assign full    = (fill == CntW'(OUT_DEPTH));
  assign empty   = (fill == '0);
  assign rd_item = mem[rd_ptr];
  assign wr_en   = push && !full;
  assign rd_en   = pop && !empty;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CntW'(wr_en) - CntW'(rd_en);
    end
  end

endmodule

### rtl/servo_bus_transaction_master.sv
// ----------------------------------------------------------------------------
// servo_bus_transaction_master
// Half-duplex servo bus master: command framing and reply checking.
// ----------------------------------------------------------------------------
// A completion passes through the request queue and the result queue on
// its way to the result ports. The back end takes one received byte or
// tick a cycle unless a frame is being sent or the result queue is full,
// and sends a start's frame one byte a cycle while the result queue has room.
// Reset clears both queues and the parse state and loads the register
// defaults: servo id 1, header timeout 5000, body timeout 10000.
// ----------------------------------------------------------------------------
module servo_bus_transaction_master
  import svbm_pkg::*;
#(
  parameter int MAX_TX_PARAMS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [7:0]  instruction,
  input  logic [2:0]  param_count,
  input  logic [7:0]  param0,
  input  logic [7:0]  param1,
  input  logic [7:0]  param2,
  input  logic [7:0]  param3,
  input  logic [7:0]  rx_byte,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic        result_kind,
  output logic [7:0]  tx_byte,
  output logic        tx_last,
  output logic [2:0]  status,
  output logic [7:0]  servo_error,
  output logic [31:0] read_value,
  output logic [7:0]  reply_param_count,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;
  logic    res_push;
  result_t res;
  logic    res_full;
  result_t head;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.servo_id       <= 8'd1;
      cfg.header_timeout <= 16'd5000;
      cfg.body_timeout   <= 16'd10000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SERVO_ID:       cfg.servo_id       <= cfg_data[7:0];
        CFG_HEADER_TIMEOUT: cfg.header_timeout <= cfg_data;
        CFG_BODY_TIMEOUT:   cfg.body_timeout   <= cfg_data;
        default:            cfg                <= cfg;
      endcase
    end
  end

  svbm_front #(
    .MAX_TX_PARAMS(MAX_TX_PARAMS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .action      (action),
    .instruction (instruction),
    .param_count (param_count),
    .param0      (param0),
    .param1      (param1),
    .param2      (param2),
    .param3      (param3),
    .rx_byte     (rx_byte),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  svbm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  svbm_out_fifo u_out (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_item (res),
    .full    (res_full),
    .pop     (pop),
    .empty   (empty),
    .rd_item (head)
  );

  // result ports
  assign result_kind       = head.kind;
  assign tx_byte           = head.tx_byte;
  assign tx_last           = head.tx_last;
  assign status            = head.status;
  assign servo_error       = head.servo_error;
  assign read_value        = head.read_value;
  assign reply_param_count = head.param_count;

endmodule

### verif/tb_servo_bus_transaction_master.sv
// ----------------------------------------------------------------------------
// tb_servo_bus_transaction_master
// Self-checking bench for the servo bus transaction master. Requests go in
// through the push/full queue: first a table of directed requests, then
// random command/reply transactions over several register settings. A
// behavioural model of the framing and reply parser predicts every transmit
// byte and completion, and each popped result is compared field by field.
// ----------------------------------------------------------------------------
module tb_servo_bus_transaction_master;
  import svbm_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PRINT_CAP     = 40;
  localparam int TX_PARAM_CAP  = 4;

  // one request as the block sees it
  typedef struct packed {
    logic [1:0]      action;
    logic [7:0]      instruction;
    logic [2:0]      count;
    logic [3:0][7:0] params;
    logic [7:0]      rx;
  } bus_request_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    BY_MODEL,
    TYPED_DONE,
    TYPED_NONE
  } row_check_t;

  typedef struct packed {
    bus_request_t req;
    row_check_t   how;
    logic [2:0]   st;
  } directed_row_t;

  // reply parser phases of the model
  typedef enum logic [2:0] {
    RP_IDLE,
    RP_SYNC1,
    RP_SYNC2,
    RP_ADDR,
    RP_SIZE,
    RP_BODY
  } reply_phase_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  action = ACT_TICK;
  logic [7:0]  instruction = 8'h00;
  logic [2:0]  param_count = 3'd0;
  logic [7:0]  param0 = 8'h00;
  logic [7:0]  param1 = 8'h00;
  logic [7:0]  param2 = 8'h00;
  logic [7:0]  param3 = 8'h00;
  logic [7:0]  rx_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic        result_kind;
  logic [7:0]  tx_byte;
  logic        tx_last;
  logic [2:0]  status;
  logic [7:0]  servo_error;
  logic [31:0] read_value;
  logic [7:0]  reply_param_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_SERVO_ID;
  logic [15:0] cfg_data = 16'h0000;

  servo_bus_transaction_master dut (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .action            (action),
    .instruction       (instruction),
    .param_count       (param_count),
    .param0            (param0),
    .param1            (param1),
    .param2            (param2),
    .param3            (param3),
    .rx_byte           (rx_byte),
    .empty             (empty),
    .pop               (pop),
    .result_kind       (result_kind),
    .tx_byte           (tx_byte),
    .tx_last           (tx_last),
    .status            (status),
    .servo_error       (servo_error),
    .read_value        (read_value),
    .reply_param_count (reply_param_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // model copy of the registers and the parser state
  logic [7:0]   id_reg;
  logic [15:0]  hdr_limit;
  logic [15:0]  body_limit;
  reply_phase_t rp;
  logic [7:0]   body_pos;
  logic [7:0]   body_len;
  logic [7:0]   csum;
  logic [7:0]   err_seen;
  logic [31:0]  value_seen;
  logic [15:0]  tick_run;

  result_t       step_out[$];
  result_t       bus_results_due[$];
  result_t       head;
  directed_row_t directed_rows[$];
  int            fail_count = 0;
  int            requests_taken = 0;
  int            cycles = 0;
  bit            calm = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycles);
  endtask

  // ---------------------------------------------------------------- model

  function automatic void clear_parse();
    rp = RP_IDLE;
    body_pos = 8'd0;
    body_len = 8'd0;
    csum = 8'd0;
    err_seen = 8'd0;
    value_seen = 32'd0;
    tick_run = 16'd0;
  endfunction

  // completion carries the reply data only on success
  function automatic void close_transaction(logic [2:0] st);
    result_t r;
    r = '0;
    r.kind = KIND_DONE;
    r.status = st;
    if (st == ST_OK) begin
      r.servo_error = err_seen;
      r.read_value = value_seen;
      r.param_count = body_len - MIN_LENGTH;
    end
    step_out.insert(step_out.size(), r);
    clear_parse();
  endfunction

  // frame a command or advance the reply parser by one request
  function automatic void servo_master_step(bus_request_t q);
    int         n;
    int         cnt;
    logic [7:0] fr [0:10];
    logic [7:0] sum;
    logic [7:0] b;
    logic       in_body;
    logic [15:0] lim;
    result_t    r;
    step_out.delete();
    b = q.rx;
    case (q.action)
      ACT_START: begin
        if (rp == RP_IDLE) begin
          n = q.count;
          if (n > TX_PARAM_CAP) n = TX_PARAM_CAP;
          fr[0] = HDR_BYTE;
          fr[1] = HDR_BYTE;
          fr[2] = id_reg;
          fr[3] = 8'(n + 2);
          fr[4] = q.instruction;
          cnt = 5;
          sum = id_reg + 8'(n + 2) + q.instruction;
          for (int k = 0; k < n; k++) begin
            fr[cnt] = q.params[k];
            sum = sum + q.params[k];
            cnt++;
          end
          fr[cnt] = ~sum;
          cnt++;
          for (int k = 0; k < cnt; k++) begin
            r = '0;
            r.kind = KIND_TX;
            r.tx_byte = fr[k];
            r.tx_last = (k == cnt - 1);
            step_out.insert(step_out.size(), r);
          end
          clear_parse();
          rp = RP_SYNC1;
        end
      end
      ACT_RX: begin
        case (rp)
          RP_SYNC1: begin
            if (b != HDR_BYTE) close_transaction(ST_HEADER);
            else rp = RP_SYNC2;
          end
          RP_SYNC2: begin
            if (b != HDR_BYTE) close_transaction(ST_HEADER);
            else rp = RP_ADDR;
          end
          RP_ADDR: begin
            if (b != id_reg) close_transaction(ST_WRONG_ID);
            else begin
              csum = b;
              rp = RP_SIZE;
            end
          end
          RP_SIZE: begin
            if (b < MIN_LENGTH) close_transaction(ST_SIZE);
            else begin
              body_len = b;
              csum = csum + b;
              body_pos = 8'd0;
              rp = RP_BODY;
            end
          end
          RP_BODY: begin
            if (body_pos == 8'd0) begin
              // error byte restarts the tick count for the body window
              err_seen = b;
              csum = csum + b;
              tick_run = 16'd0;
              body_pos = body_pos + 8'd1;
            end else if (body_pos == body_len - 8'd1) begin
              close_transaction((~csum == b) ? ST_OK : ST_CHECKSUM);
            end else begin
              // only the first four parameters land in the read value
              if (body_pos <= 8'd4) value_seen = value_seen | (32'(b) << (8 * (body_pos - 1)));
              csum = csum + b;
              body_pos = body_pos + 8'd1;
            end
          end
          default: ;
        endcase
      end
      ACT_TICK: begin
        if (rp != RP_IDLE) begin
          if (tick_run != 16'hFFFF) tick_run = tick_run + 16'd1;
          in_body = (rp == RP_BODY) && (body_pos != 8'd0);
          lim = in_body ? body_limit : hdr_limit;
          if (tick_run >= lim) close_transaction(in_body ? ST_BODY_TIMEOUT : ST_TIMEOUT);
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- result side

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (bus_results_due.size() == 0) begin
          report_mismatch("result with nothing due, tx_byte", tx_byte, 0);
        end else begin
          head = bus_results_due.pop_front();
          if (result_kind != head.kind) report_mismatch("result_kind", result_kind, head.kind);
          if (tx_byte != head.tx_byte) report_mismatch("tx_byte", tx_byte, head.tx_byte);
          if (tx_last != head.tx_last) report_mismatch("tx_last", tx_last, head.tx_last);
          if (status != head.status) report_mismatch("status", status, head.status);
          if (servo_error != head.servo_error)
            report_mismatch("servo_error", servo_error, head.servo_error);
          if (read_value != head.read_value)
            report_mismatch("read_value", read_value, head.read_value);
          if (reply_param_count != head.param_count)
            report_mismatch("reply_param_count", reply_param_count, head.param_count);
        end
      end
      pop <= calm || ($urandom_range(99) >= 10);
    end
  end

  // ---------------------------------------------------------------- request side

  task automatic send_request(bus_request_t q, row_check_t how, logic [2:0] st);
    result_t r;
    action <= q.action;
    instruction <= q.instruction;
    param_count <= q.count;
    param0 <= q.params[0];
    param1 <= q.params[1];
    param2 <= q.params[2];
    param3 <= q.params[3];
    rx_byte <= q.rx;
    push <= 1'b1;
    do @(posedge clk); while (full);
    servo_master_step(q);
    if (how == BY_MODEL) begin
      foreach (step_out[k]) bus_results_due.insert(bus_results_due.size(), step_out[k]);
    end else if (how == TYPED_DONE) begin
      r = '0;
      r.kind = KIND_DONE;
      r.status = st;
      bus_results_due.insert(bus_results_due.size(), r);
    end
    requests_taken++;
    if (!calm) begin
      while ($urandom_range(99) < 10) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  function automatic bus_request_t random_request(logic [1:0] act);
    bus_request_t q;
    q.action = act;
    q.instruction = 8'($urandom);
    q.count = 3'($urandom);
    q.params = $urandom;
    q.rx = 8'($urandom);
    return q;
  endfunction

  task automatic send_byte(logic [7:0] b);
    bus_request_t q;
    q = random_request(ACT_RX);
    q.rx = b;
    send_request(q, BY_MODEL, ST_OK);
  endtask

  // hold the sender off until every due result has been popped
  task automatic wait_for_results();
    push <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(logic [7:0] id, logic [15:0] hdr, logic [15:0] body);
    logic [1:0]  idx [3] = '{CFG_SERVO_ID, CFG_HEADER_TIMEOUT, CFG_BODY_TIMEOUT};
    logic [15:0] val [3];
    val[0] = {8'h00, id};
    val[1] = hdr;
    val[2] = body;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      if (i == 0) cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    id_reg = id;
    hdr_limit = hdr;
    body_limit = body;
  endtask

  function automatic void add_row(logic [1:0] act, logic [7:0] ins, logic [2:0] cnt,
                                  logic [31:0] prm, logic [7:0] rx, row_check_t how,
                                  logic [2:0] st);
    directed_row_t d;
    d.req.action = act;
    d.req.instruction = ins;
    d.req.count = cnt;
    d.req.params = prm;
    d.req.rx = rx;
    d.how = how;
    d.st = st;
    directed_rows.insert(directed_rows.size(), d);
  endfunction

  // one reply from the servo, sometimes damaged, with ticks and noise mixed in
  task automatic run_reply();
    logic [7:0] rb[$];
    logic [7:0] sum;
    logic [7:0] err;
    logic [7:0] p;
    int         len;
    int         sel;
    int         cut;
    int         i;
    sel = $urandom_range(99);
    if (sel < 60) len = $urandom_range(2, 6);
    else if (sel < 90) len = $urandom_range(7, 12);
    else len = $urandom_range(13, 40);
    err = ($urandom_range(1) != 0) ? 8'h00 : 8'($urandom);
    rb.insert(rb.size(), HDR_BYTE);
    rb.insert(rb.size(), HDR_BYTE);
    rb.insert(rb.size(), id_reg);
    rb.insert(rb.size(), 8'(len));
    rb.insert(rb.size(), err);
    sum = id_reg + 8'(len) + err;
    for (int k = 0; k < len - 2; k++) begin
      p = 8'($urandom);
      rb.insert(rb.size(), p);
      sum = sum + p;
    end
    rb.insert(rb.size(), ~sum);
    // damage a share of the replies
    sel = $urandom_range(99);
    if (sel >= 60 && sel < 70) begin
      rb[rb.size() - 1] = rb[rb.size() - 1] ^ 8'($urandom_range(1, 255));
    end else if (sel >= 70 && sel < 78) begin
      rb[$urandom_range(1)] = 8'($urandom_range(254));
    end else if (sel >= 78 && sel < 84) begin
      rb[2] = rb[2] ^ 8'($urandom_range(1, 255));
    end else if (sel >= 84 && sel < 90) begin
      rb[3] = 8'($urandom_range(1));
    end else if (sel >= 90) begin
      cut = $urandom_range(1, rb.size() - 1);
      while (rb.size() > cut) rb.delete(rb.size() - 1);
    end
    i = 0;
    while (i < rb.size() && rp != RP_IDLE) begin
      if ($urandom_range(99) < 12) send_request(random_request(ACT_TICK), BY_MODEL, ST_OK);
      if ($urandom_range(99) < 4 && rp != RP_IDLE)
        send_request(random_request(($urandom_range(1) != 0) ? ACT_START : ACT_UNUSED),
                     BY_MODEL, ST_OK);
      if (rp != RP_IDLE) send_byte(rb[i]);
      i++;
    end
    // finish a cut-off reply: ticks when the window is short, else bus bytes
    while (rp != RP_IDLE) begin
      if (((rp == RP_BODY && body_pos != 8'd0) ? body_limit : hdr_limit) <= 16'd64)
        send_request(random_request(ACT_TICK), BY_MODEL, ST_OK);
      else
        send_byte(8'($urandom));
    end
  endtask

  task automatic run_transactions(int n);
    int           target;
    bus_request_t q;
    target = requests_taken + n;
    while (requests_taken < target) begin
      if ($urandom_range(99) < 8) begin
        q = random_request(($urandom_range(1) != 0) ? ACT_RX : ACT_TICK);
        if ($urandom_range(3) == 0) q.action = ACT_UNUSED;
        send_request(q, BY_MODEL, ST_OK);
      end
      q = random_request(ACT_START);
      q.count = ($urandom_range(99) < 15) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
      send_request(q, BY_MODEL, ST_OK);
      run_reply();
      if ($urandom_range(99) < 6) wait_for_results();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    id_reg = 8'd1;
    hdr_limit = 16'd5000;
    body_limit = 16'd10000;
    clear_parse();

    // directed rows run with servo id 1, header window 3, body window 2
    add_row(ACT_RX, 8'h00, 3'd0, 32'h0, 8'h55, TYPED_NONE, ST_OK);
    add_row(ACT_TICK, 8'h00, 3'd0, 32'h0, 8'h00, TYPED_NONE, ST_OK);
    add_row(ACT_UNUSED, 8'h00, 3'd0, 32'h0, 8'h00, TYPED_NONE, ST_OK);
    add_row(ACT_START, 8'h01, 3'd0, 32'h0, 8'h00, BY_MODEL, ST_OK);
    // start while busy is dropped
    add_row(ACT_START, 8'h02, 3'd2, 32'h0000_0424, 8'h00, TYPED_NONE, ST_OK);
    add_row(ACT_RX, 8'h00, 3'd0, 32'h0, 8'h00, TYPED_DONE, ST_HEADER);
    // parameter count above the cap, all ones
    add_row(ACT_START, 8'hFF, 3'd7, 32'hFFFF_FFFF, 8'h00, BY_MODEL, ST_OK);
    add_row(ACT_RX, 8'h00, 3'd0, 32'h0, HDR_BYTE, BY_MODEL, ST_OK);
    add_row(ACT_RX, 8'h00, 3'd0, 32'h0, HDR_BYTE, BY_MODEL, ST_OK);
    add_row(ACT_RX, 8'h00, 3'd0, 32'h0, 8'h07, TYPED_DONE, ST_WRONG_ID);
    add_row(ACT_START, 8'h00, 3'd4, 32'h0, 8'h00, BY_MODEL, ST_OK);
    add_row(ACT_RX, 8'h00, 3'd0, 32'h0, HDR_BYTE, BY_MODEL, ST_OK);
    add_row(ACT_RX, 8'h00, 3'd0, 32'h0, HDR_BYTE, BY_MODEL, ST_OK);
    add_row(ACT_RX, 8'h00, 3'd0, 32'h0, 8'h01, BY_MODEL, ST_OK);
    add_row(ACT_RX, 8'h00, 3'd0, 32'h0, 8'h01, TYPED_DONE, ST_SIZE);
    // header window runs out on the third tick
    add_row(ACT_START, 8'h02, 3'd2, 32'h0000_0424, 8'h00, BY_MODEL, ST_OK);
    add_row(ACT_TICK, 8'h00, 3'd0, 32'h0, 8'h00, BY_MODEL, ST_OK);
    add_row(ACT_TICK, 8'h00, 3'd0, 32'h0, 8'h00, BY_MODEL, ST_OK);
    add_row(ACT_TICK, 8'h00, 3'd0, 32'h0, 8'h00, TYPED_DONE, ST_TIMEOUT);
    // body window runs out on the second tick after the error byte
    add_row(ACT_START, 8'h01, 3'd0, 32'h0, 8'h00, BY_MODEL, ST_OK);
    add_row(ACT_RX, 8'h00, 3'd0, 32'h0, HDR_BYTE, BY_MODEL, ST_OK);
    add_row(ACT_RX, 8'h00, 3'd0, 32'h0, HDR_BYTE, BY_MODEL, ST_OK);
    add_row(ACT_RX, 8'h00, 3'd0, 32'h0, 8'h01, BY_MODEL, ST_OK);
    add_row(ACT_RX, 8'h00, 3'd0, 32'h0, 8'h02, BY_MODEL, ST_OK);
    add_row(ACT_RX, 8'h00, 3'd0, 32'h0, 8'h01, BY_MODEL, ST_OK);
    add_row(ACT_TICK, 8'h00, 3'd0, 32'h0, 8'h00, BY_MODEL, ST_OK);
    add_row(ACT_TICK, 8'h00, 3'd0, 32'h0, 8'h00, TYPED_DONE, ST_BODY_TIMEOUT);

    // reset
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    write_settings(8'd1, 16'd3, 16'd2);
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].how, directed_rows[i].st);
    settle();

    // widest windows, id 254
    write_settings(8'd254, 16'hFFFF, 16'hFFFF);
    run_transactions(25);
    settle();

    // one-tick windows, no idling on either side
    write_settings(8'd0, 16'd1, 16'd1);
    calm = 1'b1;
    run_transactions(25);
    calm = 1'b0;
    settle();

    write_settings(8'($urandom_range(254)), 16'($urandom_range(1, 40)),
                   16'($urandom_range(1, 40)));
    run_transactions(25);
    settle();

    // zero windows fire on the first tick
    write_settings(8'h7F, 16'd0, 16'd0);
    run_transactions(20);

    settle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
